// ----- src/r2h_pkg.sv -----
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared widths and the stage record that travels down the divider chain of
// the RGB to HSV converter.
// ----------------------------------------------------------------------------
package r2h_pkg;

  localparam int unsigned ChanBits = 8;
  localparam int unsigned HueBits  = 16;
  // 6 * delta reaches 1530, so remainder and divisor need 11 bits.
  localparam int unsigned HueRemBits = 11;
  localparam int unsigned SatBits  = 8;
  // The saturation quotient settles in the first SatBits cells of the chain.
  localparam int unsigned NumCells = HueBits;

  typedef struct packed {
    logic [HueRemBits-1:0] hue_rem;
    logic [HueRemBits-1:0] hue_div;
    logic [HueBits-1:0]    hue_quo;
    logic [SatBits-1:0]    sat_rem;
    logic [ChanBits-1:0]   sat_div;
    logic [SatBits-1:0]    sat_low;
    logic [SatBits-1:0]    sat_quo;
    logic [ChanBits-1:0]   value;
  } r2h_stage_t;

endpackage

// ----- src/r2h_front.sv -----
// ----------------------------------------------------------------------------
// r2h_front
// Front stage: finds max, min and delta, picks the hue sector, and sets up
// the two dividends and divisors for the cell chain.
// ----------------------------------------------------------------------------
module r2h_front
  import r2h_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [ChanBits-1:0] red_i,
  input  logic [ChanBits-1:0] green_i,
  input  logic [ChanBits-1:0] blue_i,
  output logic                valid_o,
  output r2h_stage_t          data_o
);

  logic [ChanBits-1:0]   mx, mn, delta;
  logic signed [12:0]    num_raw;
  logic signed [12:0]    num_wrap;
  logic signed [12:0]    d_s;
  logic [15:0]           sat_dvd;
  logic                  gray;
  logic                  valid_q;
  r2h_stage_t            data_d, data_q;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    gray  = (delta == '0);
    d_s   = $signed({5'd0, delta});

    // Red wins ties, then green.
    if (red_i == mx) begin
      num_raw = $signed({5'd0, green_i}) - $signed({5'd0, blue_i});
    end else if (green_i == mx) begin
      num_raw = (d_s <<< 1) + $signed({5'd0, blue_i}) - $signed({5'd0, red_i});
    end else begin
      num_raw = (d_s <<< 2) + $signed({5'd0, red_i}) - $signed({5'd0, green_i});
    end
    num_wrap = num_raw[12] ? (num_raw + (d_s <<< 2) + (d_s <<< 1)) : num_raw;

    // 255 * delta as (delta << 8) - delta.
    sat_dvd = {delta, 8'd0} - {8'd0, delta};

    // A gray or black pixel divides zero by one, which yields zero quotients.
    data_d.hue_rem = gray ? '0 : num_wrap[HueRemBits-1:0];
    data_d.hue_div = gray ? HueRemBits'(1)
                          : ({3'd0, delta} << 2) + ({3'd0, delta} << 1);
    data_d.hue_quo = '0;
    data_d.sat_rem = gray ? '0 : sat_dvd[15:8];
    data_d.sat_div = gray ? ChanBits'(1) : mx;
    data_d.sat_low = gray ? '0 : sat_dvd[7:0];
    data_d.sat_quo = '0;
    data_d.value   = mx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/r2h_cell.sv -----
// ----------------------------------------------------------------------------
// r2h_cell
// One restoring division step for the hue quotient, and optionally one for
// the saturation quotient, registered toward the next cell.
// ----------------------------------------------------------------------------
module r2h_cell
  import r2h_pkg::*;
#(
  parameter bit SatStep = 1'b1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  r2h_stage_t data_i,
  output logic       valid_o,
  output r2h_stage_t data_o
);

  logic [HueRemBits:0] hue_try;
  logic [SatBits:0]    sat_try;
  logic                hue_bit, sat_bit;
  logic                valid_q;
  r2h_stage_t          data_d, data_q;

  always_comb begin
    data_d = data_i;

    hue_try = {data_i.hue_rem, 1'b0};
    hue_bit = (hue_try >= {1'b0, data_i.hue_div});
    data_d.hue_rem = hue_bit ? HueRemBits'(hue_try - {1'b0, data_i.hue_div})
                             : hue_try[HueRemBits-1:0];
    data_d.hue_quo = {data_i.hue_quo[HueBits-2:0], hue_bit};

    sat_try = {data_i.sat_rem, data_i.sat_low[SatBits-1]};
    sat_bit = (sat_try >= {1'b0, data_i.sat_div});
    if (SatStep) begin
      data_d.sat_rem = sat_bit ? SatBits'(sat_try - {1'b0, data_i.sat_div})
                               : sat_try[SatBits-1:0];
      data_d.sat_low = {data_i.sat_low[SatBits-2:0], 1'b0};
      data_d.sat_quo = {data_i.sat_quo[SatBits-2:0], sat_bit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- src/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Converts 8-bit RGB pixels into 0.16 hue, 8-bit saturation and 8-bit value.
// ----------------------------------------------------------------------------
// The converter takes one pixel every clock cycle unless stalled, and passes it
// through one front stage that finds max, min, delta and the hue
// sector, followed by a chain of 16 division cells, each producing one hue
// quotient bit (the first eight also produce one saturation bit). The hue
// quotient width sets the chain length. A stall on the output freezes the
// whole chain while a finished result waits, and the input is stalled only then.
module rgb_to_hsv_converter
  import r2h_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ChanBits-1:0] red_i,
  input  logic [ChanBits-1:0] green_i,
  input  logic [ChanBits-1:0] blue_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HueBits-1:0]  hue_o,
  output logic [SatBits-1:0]  saturation_o,
  output logic [ChanBits-1:0] brightness_value_o
);

  logic       en;
  logic       st_valid [NumCells+1];
  r2h_stage_t st_data  [NumCells+1];

  assign en         = !(st_valid[NumCells] && out_stall_i);
  assign in_stall_o = !en;

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (st_valid[0]),
    .data_o  (st_data[0])
  );

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    r2h_cell #(
      .SatStep (k < SatBits)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_valid[k]),
      .data_i  (st_data[k]),
      .valid_o (st_valid[k+1]),
      .data_o  (st_data[k+1])
    );
  end

  assign out_valid_o        = st_valid[NumCells];
  assign hue_o              = st_data[NumCells].hue_quo;
  assign saturation_o       = st_data[NumCells].sat_quo;
  assign brightness_value_o = st_data[NumCells].value;

  // Zero saturation means a gray pixel, whose hue is zero too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (saturation_o == '0) |-> (hue_o == '0))
    else $error("gray pixel with nonzero hue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (brightness_value_o == '0) |-> (saturation_o == '0))
    else $error("black pixel with nonzero saturation");

  // Both restoring divisions must end with a remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (st_data[NumCells].hue_rem < st_data[NumCells].hue_div) &&
                    (st_data[NumCells].sat_rem < st_data[NumCells].sat_div))
    else $error("division remainder out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result waiting");

endmodule

// ----- sim/tb_rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// Streams directed and random RGB pixels through the converter while both
// handshakes idle at random. Each accepted request is predicted in
// fixed point, and the hue, saturation and value that come back are checked
// in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
  import r2h_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomPixels = 550;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned CycleLimit   = 400000;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueBits-1:0]  hue;
    logic [SatBits-1:0]  sat;
    logic [ChanBits-1:0] value;
  } hsv_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ChanBits-1:0] red_i = '0;
  logic [ChanBits-1:0] green_i = '0;
  logic [ChanBits-1:0] blue_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [HueBits-1:0]  hue_o;
  logic [SatBits-1:0]  saturation_o;
  logic [ChanBits-1:0] brightness_value_o;

  pixel_t pending_px_q[$];
  hsv_t   expected_hsv_q[$];

  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned gray_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned cycle_count = 0;

  int unsigned in_gap_left = 0;
  int unsigned in_calm_left = 0;
  int unsigned out_hold_left = 0;
  int unsigned out_calm_left = 0;

  rgb_to_hsv_converter dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hue_o              (hue_o),
    .saturation_o       (saturation_o),
    .brightness_value_o (brightness_value_o)
  );

  // Expected conversion of one pixel. Red wins ties for the largest channel,
  // then green; a negative hue numerator wraps once around the circle.
  function automatic hsv_t convert_pixel(pixel_t px);
    logic [ChanBits-1:0] mx;
    logic [ChanBits-1:0] mn;
    int                  delta;
    int                  num;
    hsv_t                res;
    mx = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    mn = px.red;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn) mn = px.blue;
    delta = int'(mx) - int'(mn);
    res = '0;
    res.value = mx;
    if (mx != 0 && delta != 0) begin
      res.sat = SatBits'((255 * delta) / int'(mx));
      if (px.red == mx) begin
        num = int'(px.green) - int'(px.blue);
      end else if (px.green == mx) begin
        num = 2 * delta + int'(px.blue) - int'(px.red);
      end else begin
        num = 4 * delta + int'(px.red) - int'(px.green);
      end
      if (num < 0) num += 6 * delta;
      res.hue = HueBits'((num * 65536) / (6 * delta));
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [ChanBits-1:0] corner_value();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Random pixels, weighted toward ties, gray, dark and corner values.
  function automatic pixel_t random_pixel();
    int unsigned         roll;
    logic [ChanBits-1:0] tie;
    pixel_t              px;
    roll = $urandom_range(99);
    px.red   = ChanBits'($urandom_range(255));
    px.green = ChanBits'($urandom_range(255));
    px.blue  = ChanBits'($urandom_range(255));
    if (roll >= 60 && roll < 75) begin
      tie = ChanBits'($urandom_range(255));
      case ($urandom_range(2))
        0: begin px.red = tie; px.green = tie; end
        1: begin px.green = tie; px.blue = tie; end
        default: begin px.red = tie; px.blue = tie; end
      endcase
    end else if (roll >= 75 && roll < 85) begin
      px.red   = ChanBits'($urandom_range(3));
      px.green = ChanBits'($urandom_range(3));
      px.blue  = ChanBits'($urandom_range(3));
    end else if (roll >= 85 && roll < 92) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (roll >= 92) begin
      px.red   = corner_value();
      px.green = corner_value();
      px.blue  = corner_value();
    end
    return px;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Request side: one pixel at a time from the pending queue, with gaps.
  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    pixel_t px;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      red_i        <= '0;
      green_i      <= '0;
      blue_i       <= '0;
      in_gap_left  <= 0;
      in_calm_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        px.red   = red_i;
        px.green = green_i;
        px.blue  = blue_i;
        expected_hsv_q.push_back(convert_pixel(px));
        pixels_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // A stalled request holds its pixel.
      end else if (in_gap_left != 0) begin
        in_valid_i  <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_px_q.size() != 0) begin
        px = pending_px_q.pop_front();
        in_valid_i <= 1'b1;
        red_i      <= px.red;
        green_i    <= px.green;
        blue_i     <= px.blue;
        // The gap chosen here follows this request once it is accepted.
        if (in_calm_left != 0) begin
          in_gap_left  <= 0;
          in_calm_left <= in_calm_left - 1;
        end else begin
          in_gap_left <= idle_length();
          if ($urandom_range(39) == 0) in_calm_left <= $urandom_range(120, 30);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: check each accepted result, then choose the next stall.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    hsv_t want;
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      out_hold_left <= 0;
      out_calm_left <= 0;
    end else begin
      if (out_stall_i) stall_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_hsv_q.size() == 0) begin
          report_mismatch("result with no pixel outstanding", 1, 0);
        end else begin
          want = expected_hsv_q.pop_front();
          if (hue_o !== want.hue) report_mismatch("hue", hue_o, want.hue);
          if (saturation_o !== want.sat) begin
            report_mismatch("saturation", saturation_o, want.sat);
          end
          if (brightness_value_o !== want.value) begin
            report_mismatch("value", brightness_value_o, want.value);
          end
          pixels_checked++;
        end
      end
      if (out_hold_left != 0) begin
        out_stall_i   <= 1'b1;
        out_hold_left <= out_hold_left - 1;
      end else if (out_calm_left != 0) begin
        out_stall_i   <= 1'b0;
        out_calm_left <= out_calm_left - 1;
      end else if ($urandom_range(4) == 0) begin
        out_stall_i   <= 1'b1;
        out_hold_left <= idle_length();
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(59) == 0) out_calm_left <= $urandom_range(150, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_hsv_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t directed[$];
    directed = '{
      '{8'd0,   8'd0,   8'd0},    // black
      '{8'd255, 8'd255, 8'd255},  // white
      '{8'd128, 8'd128, 8'd128},  // mid gray
      '{8'd1,   8'd1,   8'd1},    // darkest gray
      '{8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd1},    // red sector, numerator wraps
      '{8'd255, 8'd1,   8'd0},
      '{8'd255, 8'd255, 8'd0},    // red and green tie
      '{8'd0,   8'd255, 8'd255},  // green and blue tie
      '{8'd255, 8'd0,   8'd255},  // red and blue tie
      '{8'd1,   8'd0,   8'd0},
      '{8'd0,   8'd1,   8'd0},
      '{8'd0,   8'd0,   8'd1},
      '{8'd255, 8'd254, 8'd254},  // smallest delta at full value
      '{8'd254, 8'd255, 8'd0},
      '{8'd1,   8'd0,   8'd255},
      '{8'd255, 8'd128, 8'd64},
      '{8'd10,  8'd200, 8'd30},
      '{8'd200, 8'd10,  8'd30},
      '{8'd170, 8'd85,  8'd255}
    };
    foreach (directed[i]) pending_px_q.push_back(directed[i]);
    for (int i = 0; i < RandomPixels; i++) pending_px_q.push_back(random_pixel());
    foreach (pending_px_q[i]) begin
      if (pending_px_q[i].red == pending_px_q[i].green &&
          pending_px_q[i].green == pending_px_q[i].blue) gray_count++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_px_q.size() != 0 || in_valid_i || expected_hsv_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);

    if (expected_hsv_q.size() != 0) begin
      report_mismatch("results never returned", 0, expected_hsv_q.size());
    end
    $display("Converted %0d pixels (%0d directed, %0d gray or black), %0d checked;",
             pixels_sent, directed.size(), gray_count, pixels_checked);
    $display("output stalled on %0d of %0d cycles, %0d mismatches.",
             stall_cycles, cycle_count, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/r2h_pkg.sv
src/r2h_front.sv
src/r2h_cell.sv
src/rgb_to_hsv_converter.sv
sim/tb_rgb_to_hsv_converter.sv
